// ===== hdl/tlvf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvf_pkg
// Shared types and constants of the subrecord finder.
// ----------------------------------------------------------------------------
package tlvf_pkg;

    localparam int POS_BITS    = 24;
    localparam int SIZE_BITS   = 32;
    localparam int ID_BITS     = 32;
    localparam int OCC_BITS    = 8;
    localparam int STATUS_BITS = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [STATUS_BITS-1:0] ST_FOUND   = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_END     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_ZERO    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_TRUNC   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_OVERRUN = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One classified input byte: an optional payload result and an
    // optional end-of-record summary.
    typedef struct packed {
        logic                   has_pay;
        logic [7:0]             data;
        logic                   plast;
        logic                   has_sum;
        logic                   found;
        logic [STATUS_BITS-1:0] status;
        logic [POS_BITS-1:0]    position;
        logic [SIZE_BITS-1:0]   size;
    } t_event;

endpackage

// ===== hdl/tlvf_if.sv =====
// ----------------------------------------------------------------------------
// tlvf_if
// Request channels of the subrecord finder: record bytes in, results out.
// ----------------------------------------------------------------------------
interface tlvf_rec_if;
    logic       valid;
    logic       ready;
    logic [7:0] record_byte;
    logic       record_last;

    modport source (output valid, output record_byte, output record_last, input ready);
    modport sink   (input valid, input record_byte, input record_last, output ready);
endinterface

interface tlvf_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic        payload_last;
    logic        found;
    logic [2:0]  stop_status;
    logic [23:0] found_position;
    logic [31:0] found_size;
    logic        last;

    modport source (output valid, output kind, output data_byte, output payload_last,
                    output found, output stop_status, output found_position,
                    output found_size, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input payload_last,
                    input found, input stop_status, input found_position,
                    input found_size, input last, output ready);
endinterface

// ===== hdl/tlvf_front.sv =====
// ----------------------------------------------------------------------------
// tlvf_front
// Accepts record bytes, walks the record and subrecord headers and turns
// each matched payload byte and each record's final byte into an event for the result queue.
// ----------------------------------------------------------------------------
module tlvf_front #(
    parameter int RECORD_HEADER_BYTES = 16,
    parameter int OFFSET_BITS         = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tlvf_rec_if.sink                  i_rec,
    input  logic [31:0]               i_target_id,
    input  logic [7:0]                i_occurrence,
    input  logic                      i_full,
    output logic                      o_push,
    output tlvf_pkg::t_event          o_event
);
    import tlvf_pkg::*;

    typedef enum logic [4:0] {
        PH_SKIP      = 5'b00001,
        PH_SUBHDR    = 5'b00010,
        PH_PAY_SKIP  = 5'b00100,
        PH_PAY_MATCH = 5'b01000,
        PH_DONE      = 5'b10000
    } t_phase;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] HDR_END  = OFFSET_BITS'(RECORD_HEADER_BYTES);
    localparam t_phase                 PH_START = (RECORD_HEADER_BYTES == 0) ? PH_SUBHDR
                                                                             : PH_SKIP;

    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    t_phase                 r_phase, n_phase;
    logic [2:0]             r_hidx, n_hidx;
    logic [ID_BITS-1:0]     r_cur_id, n_cur_id;
    logic [SIZE_BITS-1:0]   r_sub_size, n_sub_size;
    logic [SIZE_BITS-1:0]   r_bytes_left, n_bytes_left;
    logic [OCC_BITS-1:0]    r_match_cnt, n_match_cnt;
    logic [OFFSET_BITS-1:0] r_res_pos, n_res_pos;
    logic [SIZE_BITS-1:0]   r_res_size, n_res_size;
    logic [STATUS_BITS-1:0] r_stop, n_stop;

    logic                   accept;
    logic [7:0]             b;
    logic                   lastb;
    logic [OFFSET_BITS-1:0] next_off;
    logic [ID_BITS-1:0]     id_base;
    logic [SIZE_BITS-1:0]   size_base;
    logic [SIZE_BITS-1:0]   bl_dec;
    logic [4:0]             lane_shift;
    logic                   found;
    t_event                 ev;

    assign i_rec.ready = !i_full;
    assign accept      = i_rec.valid && !i_full;
    assign b           = i_rec.record_byte;
    assign lastb       = i_rec.record_last;
    assign next_off    = (r_offset != OFF_MAX) ? r_offset + 1'b1 : r_offset;
    assign lane_shift  = {r_hidx[1:0], 3'b000};
    assign id_base     = (r_hidx == 3'd0) ? '0 : r_cur_id;
    assign size_base   = (r_hidx == 3'd0) ? '0 : r_sub_size;
    assign bl_dec      = (r_bytes_left != '0) ? r_bytes_left - 1'b1 : r_bytes_left;

    always_comb begin
        n_offset     = next_off;
        n_phase      = r_phase;
        n_hidx       = r_hidx;
        n_cur_id     = r_cur_id;
        n_sub_size   = r_sub_size;
        n_bytes_left = r_bytes_left;
        n_match_cnt  = r_match_cnt;
        n_res_pos    = r_res_pos;
        n_res_size   = r_res_size;
        n_stop       = r_stop;
        ev           = '0;

        unique case (r_phase)
            PH_SKIP: begin
                if (next_off >= HDR_END) begin
                    n_phase = PH_SUBHDR;
                end
                if (lastb) begin
                    if (n_phase == PH_SUBHDR) begin
                        n_stop    = ST_END;
                        n_res_pos = next_off;
                    end else begin
                        n_stop    = ST_TRUNC;
                        n_res_pos = HDR_END;
                    end
                end
            end
            PH_SUBHDR: begin
                if (r_hidx == 3'd0) begin
                    n_res_pos = r_offset;
                end
                n_cur_id   = id_base;
                n_sub_size = size_base;
                if (!r_hidx[2]) begin
                    n_cur_id = id_base | (ID_BITS'(b) << lane_shift);
                end else begin
                    n_sub_size = size_base | (SIZE_BITS'(b) << lane_shift);
                end
                n_hidx = r_hidx + 3'd1;
                if (r_hidx == 3'd7) begin
                    if (n_sub_size == '0) begin
                        n_stop  = ST_ZERO;
                        n_phase = PH_DONE;
                    end else begin
                        n_bytes_left = n_sub_size;
                        n_phase      = PH_PAY_SKIP;
                        if (n_cur_id == i_target_id) begin
                            if (r_match_cnt == i_occurrence) begin
                                n_phase = PH_PAY_MATCH;
                            end else if (r_match_cnt != {OCC_BITS{1'b1}}) begin
                                n_match_cnt = r_match_cnt + 1'b1;
                            end
                        end
                    end
                end
                if (lastb && n_phase != PH_DONE) begin
                    n_stop = (n_phase == PH_SUBHDR) ? ST_TRUNC : ST_OVERRUN;
                end
            end
            PH_PAY_SKIP, PH_PAY_MATCH: begin
                n_bytes_left = bl_dec;
                if (r_phase == PH_PAY_MATCH) begin
                    ev.has_pay = 1'b1;
                    ev.data    = b;
                    ev.plast   = (bl_dec == '0);
                end
                if (bl_dec == '0) begin
                    if (r_phase == PH_PAY_MATCH) begin
                        n_stop     = ST_FOUND;
                        n_res_size = r_sub_size;
                        n_phase    = PH_DONE;
                    end else begin
                        n_phase = PH_SUBHDR;
                        n_hidx  = 3'd0;
                    end
                end
                if (lastb && n_phase != PH_DONE) begin
                    if (n_phase == PH_SUBHDR) begin
                        n_stop    = ST_END;
                        n_res_pos = next_off;
                    end else begin
                        n_stop = ST_OVERRUN;
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        found = (n_stop == ST_FOUND);
        if (lastb) begin
            ev.has_sum  = 1'b1;
            ev.found    = found;
            ev.status   = n_stop;
            ev.position = POS_BITS'(n_res_pos);
            ev.size     = found ? n_res_size : '0;
            n_offset     = '0;
            n_phase      = PH_START;
            n_hidx       = '0;
            n_cur_id     = '0;
            n_sub_size   = '0;
            n_bytes_left = '0;
            n_match_cnt  = '0;
            n_res_pos    = '0;
            n_res_size   = '0;
            n_stop       = '0;
        end
    end

    assign o_push  = accept && (ev.has_pay || ev.has_sum);
    assign o_event = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= '0;
            r_phase      <= PH_START;
            r_hidx       <= '0;
            r_cur_id     <= '0;
            r_sub_size   <= '0;
            r_bytes_left <= '0;
            r_match_cnt  <= '0;
            r_res_pos    <= '0;
            r_res_size   <= '0;
            r_stop       <= '0;
        end else if (accept) begin
            r_offset     <= n_offset;
            r_phase      <= n_phase;
            r_hidx       <= n_hidx;
            r_cur_id     <= n_cur_id;
            r_sub_size   <= n_sub_size;
            r_bytes_left <= n_bytes_left;
            r_match_cnt  <= n_match_cnt;
            r_res_pos    <= n_res_pos;
            r_res_size   <= n_res_size;
            r_stop       <= n_stop;
        end
    end

endmodule

// ===== hdl/tlvf_queue.sv =====
// ----------------------------------------------------------------------------
// tlvf_queue
// Short first-in first-out queue of events between the front and back parts.
// ----------------------------------------------------------------------------
module tlvf_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tlvf_pkg::t_event i_event,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output tlvf_pkg::t_event o_head
);
    import tlvf_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    t_event              r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wptr, r_rptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/tlvf_back.sv =====
// ----------------------------------------------------------------------------
// tlvf_back
// Expands queued events into result requests and holds them in the output
// register until the consumer takes them.
// ----------------------------------------------------------------------------
module tlvf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  tlvf_pkg::t_event i_head,
    output logic             o_pop,
    tlvf_res_if.source       o_res
);
    import tlvf_pkg::*;

    logic                   r_ovalid;
    logic                   r_part;
    logic                   r_kind;
    logic [7:0]             r_data;
    logic                   r_plast;
    logic                   r_found;
    logic [STATUS_BITS-1:0] r_status;
    logic [POS_BITS-1:0]    r_pos;
    logic [SIZE_BITS-1:0]   r_size;
    logic                   load;
    logic                   take;
    logic                   send_pay;

    assign load     = !r_ovalid || o_res.ready;
    assign take     = load && !i_empty;
    assign send_pay = i_head.has_pay && !r_part;
    // The event leaves the queue with its final request.
    assign o_pop    = take && !(send_pay && i_head.has_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_part   <= 1'b0;
        end else if (load) begin
            r_ovalid <= !i_empty;
            if (take) begin
                r_part <= !o_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (send_pay) begin
                r_kind   <= KIND_PAYLOAD;
                r_data   <= i_head.data;
                r_plast  <= i_head.plast;
                r_found  <= 1'b0;
                r_status <= '0;
                r_pos    <= '0;
                r_size   <= '0;
            end else begin
                r_kind   <= KIND_SUMMARY;
                r_data   <= '0;
                r_plast  <= 1'b0;
                r_found  <= i_head.found;
                r_status <= i_head.status;
                r_pos    <= i_head.position;
                r_size   <= i_head.size;
            end
        end
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.kind           = r_kind;
    assign o_res.data_byte      = r_data;
    assign o_res.payload_last   = r_plast;
    assign o_res.found          = r_found;
    assign o_res.stop_status    = r_status;
    assign o_res.found_position = r_pos;
    assign o_res.found_size     = r_size;
    assign o_res.last           = (r_kind == KIND_SUMMARY);

endmodule

// ===== hdl/tlv_subrecord_finder.sv =====
// ----------------------------------------------------------------------------
// tlv_subrecord_finder
// Finds one subrecord in a byte-streamed record and streams its payload.
// ----------------------------------------------------------------------------
// The block takes one record byte per clock cycle while the queue is not
// full, with no gaps of its own. Each byte is classified by the front part
// in the cycle it is accepted and leaves at most one event in a four-entry
// queue; the back part turns each event into result requests through a
// single output register, one per cycle while the consumer is ready. Only
// a record's last byte inside the matched payload yields two requests. The
// user must write the id sought and the occurrence over the register port
// only while no record is in flight; the block itself does not enforce it.
module tlv_subrecord_finder #(
    parameter int RECORD_HEADER_BYTES = 16,
    parameter int OFFSET_BITS         = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlvf_rec_if.sink    i_rec,
    tlvf_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tlvf_pkg::*;

    logic [ID_BITS-1:0]  r_target_id;
    logic [OCC_BITS-1:0] r_occurrence;
    logic                cfg_write;
    logic                q_push, q_pop, q_full, q_empty;
    t_event              q_in, q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = paddr[2] ? 32'(r_occurrence) : r_target_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id  <= '0;
            r_occurrence <= '0;
        end else if (cfg_write) begin
            if (paddr[2]) begin
                r_occurrence <= pwdata[OCC_BITS-1:0];
            end else begin
                r_target_id <= pwdata;
            end
        end
    end

    tlvf_front #(
        .RECORD_HEADER_BYTES (RECORD_HEADER_BYTES),
        .OFFSET_BITS         (OFFSET_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec        (i_rec),
        .i_target_id  (r_target_id),
        .i_occurrence (r_occurrence),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_event      (q_in)
    );

    tlvf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_event (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    tlvf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule
